// ----- rtl/capsule_button_pixel_shader_macros.svh -----
// ----------------------------------------------------------------------------
// capsule button pixel shader assertion macros
// property shorthands shared by the checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef CAPSULE_BUTTON_PIXEL_SHADER_MACROS_SVH
`define CAPSULE_BUTTON_PIXEL_SHADER_MACROS_SVH

// condition and consequence in the same cycle
`define CBPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define CBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/cbps_pkg.sv -----
// ----------------------------------------------------------------------------
// cbps_pkg
// widths, codes and payload types of the capsule button pixel shader
// ----------------------------------------------------------------------------
package cbps_pkg;

    localparam int COORD_WIDTH_BITS  = 12;
    localparam int COORD_HEIGHT_BITS = 10;

    // radius and root width, radicand and remainder widths
    localparam int ROOT_BITS   = COORD_HEIGHT_BITS - 1;
    localparam int RAD_SQ_BITS = 2 * ROOT_BITS;
    localparam int REM_BITS    = ROOT_BITS + 2;

    // signed span for the column compares
    localparam int SPAN_BITS = ((COORD_WIDTH_BITS > COORD_HEIGHT_BITS) ?
                                COORD_WIDTH_BITS : COORD_HEIGHT_BITS) + 2;

    localparam int COLOR_BITS = 24;
    localparam int MODE_BITS  = 2;
    localparam int CLASS_BITS = 2;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    localparam logic [COORD_WIDTH_BITS-1:0]  WIDTH_RESET  = COORD_WIDTH_BITS'(64);
    localparam logic [COORD_HEIGHT_BITS-1:0] HEIGHT_RESET = COORD_HEIGHT_BITS'(32);
    localparam logic [MODE_BITS-1:0]         MODE_RESET   = '0;
    localparam logic [COLOR_BITS-1:0]        BACK_RESET   = '0;
    localparam logic [COLOR_BITS-1:0]        EDGE_RESET   = '0;
    localparam logic [COLOR_BITS-1:0]        FACE_RESET   = '1;

    // draw modes, the unused fourth code draws like solid fill
    localparam logic [MODE_BITS-1:0] MODE_FILLED   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_OUTLINED = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_SOLID    = 2'd2;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_MODE   = 3'd2,
        REG_BACK   = 3'd3,
        REG_EDGE   = 3'd4,
        REG_FACE   = 3'd5
    } t_reg_idx;

    typedef enum logic [CLASS_BITS-1:0] {
        CLASS_BACK = 2'd0,
        CLASS_EDGE = 2'd1,
        CLASS_FACE = 2'd2
    } t_pix_class;

    typedef struct packed {
        logic [COORD_WIDTH_BITS-1:0]  pixel_x;
        logic [COORD_HEIGHT_BITS-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [COLOR_BITS-1:0] pixel_color;
        logic [CLASS_BITS-1:0] pixel_class;
    } t_pix_out;

    typedef struct packed {
        logic [COORD_WIDTH_BITS-1:0]  image_width;
        logic [COORD_HEIGHT_BITS-1:0] image_height;
        logic [MODE_BITS-1:0]         draw_mode;
        logic [COLOR_BITS-1:0]        back_color;
        logic [COLOR_BITS-1:0]        edge_color;
        logic [COLOR_BITS-1:0]        face_color;
    } t_cfg;

    // one square root in flight: radicand bits still to consume, root, remainder
    typedef struct packed {
        logic [RAD_SQ_BITS-1:0] n;
        logic [ROOT_BITS-1:0]   q;
        logic [REM_BITS-1:0]    rem;
    } t_root_lane;

    // per-pixel facts that ride along the root chain
    typedef struct packed {
        logic [COORD_WIDTH_BITS-1:0] x;
        logic                        in_img;
        logic                        edge_row;
        logic                        has_next;
    } t_side;

endpackage

// ----- rtl/cbps_root_cell.sv -----
// ----------------------------------------------------------------------------
// cbps_root_cell
// one digit of two integer square roots, registered, with pass-along data
// ----------------------------------------------------------------------------
module cbps_root_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  cbps_pkg::t_root_lane  i_lane0,
    input  cbps_pkg::t_root_lane  i_lane1,
    input  cbps_pkg::t_side       i_side,
    input  logic                  i_down_en,
    output logic                  o_up_en,
    output logic                  o_valid,
    output cbps_pkg::t_root_lane  o_lane0,
    output cbps_pkg::t_root_lane  o_lane1,
    output cbps_pkg::t_side       o_side
);

    localparam int QB = cbps_pkg::ROOT_BITS;
    localparam int NB = cbps_pkg::RAD_SQ_BITS;
    localparam int RB = cbps_pkg::REM_BITS;

    // restoring root step on the top two radicand bits
    function automatic cbps_pkg::t_root_lane root_step(input cbps_pkg::t_root_lane lane);
        logic [RB+1:0]        acc;
        logic [RB+1:0]        trial;
        logic [RB+1:0]        diff;
        cbps_pkg::t_root_lane nxt;
        acc   = {lane.rem, lane.n[NB-1 -: 2]};
        trial = {2'b00, lane.q, 2'b01};
        diff  = acc - trial;
        nxt.n = {lane.n[NB-3:0], 2'b00};
        if (acc >= trial) begin
            nxt.rem = diff[RB-1:0];
            nxt.q   = {lane.q[QB-2:0], 1'b1};
        end else begin
            nxt.rem = acc[RB-1:0];
            nxt.q   = {lane.q[QB-2:0], 1'b0};
        end
        return nxt;
    endfunction

    logic                 r_valid;
    cbps_pkg::t_root_lane r_lane0;
    cbps_pkg::t_root_lane r_lane1;
    cbps_pkg::t_side      r_side;
    cbps_pkg::t_root_lane n_lane0;
    cbps_pkg::t_root_lane n_lane1;
    logic                 advance;

    // cell takes new data when empty or when the next one takes ours
    assign advance = !r_valid || i_down_en;
    assign n_lane0 = root_step(i_lane0);
    assign n_lane1 = root_step(i_lane1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_lane0 <= n_lane0;
            r_lane1 <= n_lane1;
            r_side  <= i_side;
        end
    end

    assign o_up_en = advance;
    assign o_valid = r_valid;
    assign o_lane0 = r_lane0;
    assign o_lane1 = r_lane1;
    assign o_side  = r_side;

endmodule

// ----- rtl/cbps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cbps_cfg_regs
// register file behind the bus port: size, mode and the three colors
// ----------------------------------------------------------------------------
module cbps_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbps_pkg::ADDR_BITS-1:0] paddr,
    input  logic [cbps_pkg::DATA_BITS-1:0] pwdata,
    output logic [cbps_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output cbps_pkg::t_cfg                 o_cfg
);

    localparam int WB = cbps_pkg::COORD_WIDTH_BITS;
    localparam int HB = cbps_pkg::COORD_HEIGHT_BITS;
    localparam int MB = cbps_pkg::MODE_BITS;
    localparam int CB = cbps_pkg::COLOR_BITS;
    localparam int DB = cbps_pkg::DATA_BITS;
    localparam int AB = cbps_pkg::ADDR_BITS;

    cbps_pkg::t_cfg   r_cfg;
    cbps_pkg::t_cfg   n_cfg;
    cbps_pkg::t_reg_idx idx;
    logic             wr;

    assign idx    = cbps_pkg::t_reg_idx'(paddr[AB-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            unique case (idx)
                cbps_pkg::REG_WIDTH:  n_cfg.image_width  = pwdata[WB-1:0];
                cbps_pkg::REG_HEIGHT: n_cfg.image_height = pwdata[HB-1:0];
                cbps_pkg::REG_MODE:   n_cfg.draw_mode    = pwdata[MB-1:0];
                cbps_pkg::REG_BACK:   n_cfg.back_color   = pwdata[CB-1:0];
                cbps_pkg::REG_EDGE:   n_cfg.edge_color   = pwdata[CB-1:0];
                cbps_pkg::REG_FACE:   n_cfg.face_color   = pwdata[CB-1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            cbps_pkg::REG_WIDTH:  prdata = DB'(r_cfg.image_width);
            cbps_pkg::REG_HEIGHT: prdata = DB'(r_cfg.image_height);
            cbps_pkg::REG_MODE:   prdata = DB'(r_cfg.draw_mode);
            cbps_pkg::REG_BACK:   prdata = DB'(r_cfg.back_color);
            cbps_pkg::REG_EDGE:   prdata = DB'(r_cfg.edge_color);
            cbps_pkg::REG_FACE:   prdata = DB'(r_cfg.face_color);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= cbps_pkg::WIDTH_RESET;
            r_cfg.image_height <= cbps_pkg::HEIGHT_RESET;
            r_cfg.draw_mode    <= cbps_pkg::MODE_RESET;
            r_cfg.back_color   <= cbps_pkg::BACK_RESET;
            r_cfg.edge_color   <= cbps_pkg::EDGE_RESET;
            r_cfg.face_color   <= cbps_pkg::FACE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/capsule_button_pixel_shader.sv -----
// ----------------------------------------------------------------------------
// capsule_button_pixel_shader
// colors one pixel of a capsule-shaped button as background, outline or face
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  in        request    i_in_valid / o_in_stall    i_in_data  (pixel_x, pixel_y)
//  out       result     o_out_valid / i_out_stall  o_out_data (pixel_color, pixel_class)
//  cfg       bus write  psel, penable, pwrite      paddr, pwdata, prdata
//
//  one pixel per clock while the output is not stalled; each request passes
//  mirror, multiply, one root cell per root bit, round and inset, then classify
//  into the output register
//  the chain of root cells sets the latency, one bit of both roots per cell
//  reset clears every valid flag and loads the register defaults, no sweep
//  a stage holds only while it is full and its successor cannot take, so
//  empty slots close up and a waiting result never blocks a free input stage
//
module capsule_button_pixel_shader (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration bus
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cbps_pkg::ADDR_BITS-1:0] paddr,
    input  logic [cbps_pkg::DATA_BITS-1:0] pwdata,
    output logic [cbps_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    // pixel requests
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cbps_pkg::t_pix_in              i_in_data,
    // pixel results
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cbps_pkg::t_pix_out             o_out_data
);

    localparam int WB = cbps_pkg::COORD_WIDTH_BITS;
    localparam int HB = cbps_pkg::COORD_HEIGHT_BITS;
    localparam int QB = cbps_pkg::ROOT_BITS;
    localparam int NB = cbps_pkg::RAD_SQ_BITS;
    localparam int SW = cbps_pkg::SPAN_BITS;

    // ------------------------------------------------------------------
    // configuration registers and the derived image geometry
    // ------------------------------------------------------------------
    cbps_pkg::t_cfg cfg;

    cbps_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [QB-1:0] radius;
    logic [HB-1:0] img_h;
    logic [HB-1:0] last_row;
    logic [WB-1:0] img_w;

    // sizes are forced even, radius is half the height
    assign radius   = cfg.image_height[HB-1:1];
    assign img_h    = {radius, 1'b0};
    assign img_w    = {cfg.image_width[WB-1:1], 1'b0};
    assign last_row = img_h - HB'(1);

    // ------------------------------------------------------------------
    // stall chain, each stage moves when empty or drained downstream
    // ------------------------------------------------------------------
    logic en_p1;
    logic en_p2;
    logic en_f1;
    logic en_out;
    logic c_en [QB+1];

    logic r_p1_valid;
    logic r_p2_valid;
    logic r_f1_valid;
    logic r_out_valid;

    assign en_out     = !r_out_valid || !i_out_stall;
    assign en_f1      = !r_f1_valid || en_out;
    assign c_en[QB]   = en_f1;
    assign en_p2      = !r_p2_valid || c_en[0];
    assign en_p1      = !r_p1_valid || en_p2;
    assign o_in_stall = !en_p1;

    // ------------------------------------------------------------------
    // stage p1: bounds, edge rows, mirror the row into the upper half
    // ------------------------------------------------------------------
    cbps_pkg::t_side r_p1_side;
    cbps_pkg::t_side n_p1_side;
    logic [QB-1:0]   r_p1_m;
    logic [QB-1:0]   n_p1_m;
    logic [HB-1:0]   y_mir;
    logic [HB:0]     m_next;

    always_comb begin
        if (i_in_data.pixel_y < {1'b0, radius}) begin
            y_mir = i_in_data.pixel_y;
        end else begin
            y_mir = last_row - i_in_data.pixel_y;
        end
        m_next             = {1'b0, y_mir} + (HB+1)'(1);
        n_p1_side.x        = i_in_data.pixel_x;
        n_p1_side.in_img   = (i_in_data.pixel_x < img_w) && (i_in_data.pixel_y < img_h);
        n_p1_side.edge_row = (i_in_data.pixel_y == '0) || (i_in_data.pixel_y == last_row);
        // middle row has no next row, its slope counts as zero
        n_p1_side.has_next = m_next < {2'b00, radius};
        n_p1_m             = y_mir[QB-1:0];
    end

    // ------------------------------------------------------------------
    // stage p2: radicands m*(2r-m) for this row and the next one
    // ------------------------------------------------------------------
    cbps_pkg::t_side      r_p2_side;
    cbps_pkg::t_root_lane r_p2_lane0;
    cbps_pkg::t_root_lane r_p2_lane1;
    cbps_pkg::t_root_lane n_p2_lane0;
    cbps_pkg::t_root_lane n_p2_lane1;
    logic [QB:0]          two_r;
    logic [QB:0]          m_inc;
    logic [QB:0]          span0;
    logic [QB:0]          span1;
    logic [NB-1:0]        prod0;
    logic [NB-1:0]        prod1;

    always_comb begin
        two_r          = {radius, 1'b0};
        m_inc          = {1'b0, r_p1_m} + (QB+1)'(1);
        span0          = two_r - {1'b0, r_p1_m};
        span1          = two_r - m_inc;
        // radicand never exceeds r*r, so it fits the root width squared
        prod0          = NB'(r_p1_m) * NB'(span0);
        prod1          = NB'(m_inc) * NB'(span1);
        n_p2_lane0.n   = prod0;
        n_p2_lane0.q   = '0;
        n_p2_lane0.rem = '0;
        n_p2_lane1.n   = prod1;
        n_p2_lane1.q   = '0;
        n_p2_lane1.rem = '0;
    end

    // ------------------------------------------------------------------
    // root chain: one cell per root bit, both roots side by side
    // ------------------------------------------------------------------
    logic                 c_valid [QB+1];
    cbps_pkg::t_root_lane c_lane0 [QB+1];
    cbps_pkg::t_root_lane c_lane1 [QB+1];
    cbps_pkg::t_side      c_side  [QB+1];

    assign c_valid[0] = r_p2_valid;
    assign c_lane0[0] = r_p2_lane0;
    assign c_lane1[0] = r_p2_lane1;
    assign c_side[0]  = r_p2_side;

    for (genvar k = 0; k < QB; k++) begin : g_cell
        cbps_root_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (c_valid[k]),
            .i_lane0   (c_lane0[k]),
            .i_lane1   (c_lane1[k]),
            .i_side    (c_side[k]),
            .i_down_en (c_en[k+1]),
            .o_up_en   (c_en[k]),
            .o_valid   (c_valid[k+1]),
            .o_lane0   (c_lane0[k+1]),
            .o_lane1   (c_lane1[k+1]),
            .o_side    (c_side[k+1])
        );
    end

    // ------------------------------------------------------------------
    // stage f1: round the roots, insets of both rows, outline slope
    // ------------------------------------------------------------------
    // round to nearest, halves down: bump when remainder exceeds the root
    function automatic logic [QB-1:0] inset_of(input cbps_pkg::t_root_lane lane,
                                               input logic [QB-1:0] rad);
        logic [QB:0] s;
        s = {1'b0, lane.q} + (QB+1)'(lane.rem > {2'b00, lane.q});
        return rad - s[QB-1:0];
    endfunction

    cbps_pkg::t_side r_f1_side;
    logic [QB-1:0]   r_f1_ins;
    logic [QB-1:0]   r_f1_xa;
    logic            r_f1_zero;
    logic            r_f1_steep;
    logic [QB-1:0]   ins0;
    logic [QB-1:0]   ins1;
    logic [QB-1:0]   n_f1_xa;
    logic            n_f1_steep;

    always_comb begin
        ins0 = inset_of(c_lane0[QB], radius);
        ins1 = inset_of(c_lane1[QB], radius);
        // inset minus slope is simply the next row's inset
        n_f1_xa    = c_side[QB].has_next ? ins1 : ins0;
        // flat or steep row: zero slope, or inset minus slope below two
        n_f1_steep = !c_side[QB].has_next || (ins0 == ins1) ||
                     (n_f1_xa == '0) || (n_f1_xa == QB'(1));
    end

    // ------------------------------------------------------------------
    // stage f2: classify against the insets, pick the color
    // ------------------------------------------------------------------
    logic signed [SW-1:0]  xs;
    logic signed [SW-1:0]  ins_s;
    logic signed [SW-1:0]  xa_s;
    logic signed [SW-1:0]  w_ins;
    logic signed [SW-1:0]  w_xa;
    logic signed [SW-1:0]  w_m1;
    cbps_pkg::t_pix_class  cls;
    cbps_pkg::t_pix_out    r_out;
    cbps_pkg::t_pix_out    n_out;

    always_comb begin
        xs    = SW'(r_f1_side.x);
        ins_s = SW'(r_f1_ins);
        xa_s  = SW'(r_f1_xa);
        w_ins = SW'(img_w) - ins_s;
        w_xa  = SW'(img_w) - xa_s;
        w_m1  = SW'(img_w) - SW'(1);
        cls   = cbps_pkg::CLASS_BACK;
        if (r_f1_side.in_img) begin
            if (cfg.draw_mode >= cbps_pkg::MODE_SOLID) begin
                cls = cbps_pkg::CLASS_FACE;
            end else if (cfg.draw_mode == cbps_pkg::MODE_FILLED) begin
                cls = (xs < ins_s || xs >= w_ins) ? cbps_pkg::CLASS_BACK
                                                  : cbps_pkg::CLASS_FACE;
            end else if (r_f1_side.edge_row) begin
                // top and bottom rows are all outline between the ends
                cls = (xs < xa_s || xs > w_xa) ? cbps_pkg::CLASS_BACK
                                               : cbps_pkg::CLASS_EDGE;
            end else if (r_f1_zero) begin
                // straight sides: outline only in the first and last column
                cls = (xs == '0 || xs == w_m1) ? cbps_pkg::CLASS_EDGE
                                               : cbps_pkg::CLASS_FACE;
            end else if (r_f1_steep) begin
                // single outline pixel at each inset
                if (xs == ins_s || xs == w_ins) begin
                    cls = cbps_pkg::CLASS_EDGE;
                end else if (xs < ins_s || xs > w_ins) begin
                    cls = cbps_pkg::CLASS_BACK;
                end else begin
                    cls = cbps_pkg::CLASS_FACE;
                end
            end else begin
                // outline run from next row's inset up to this row's inset
                if (xs < xa_s || xs > w_xa) begin
                    cls = cbps_pkg::CLASS_BACK;
                end else if (xs >= ins_s && xs <= w_ins) begin
                    cls = cbps_pkg::CLASS_FACE;
                end else begin
                    cls = cbps_pkg::CLASS_EDGE;
                end
            end
        end
        n_out.pixel_class = cls;
        case (cls)
            cbps_pkg::CLASS_EDGE: n_out.pixel_color = cfg.edge_color;
            cbps_pkg::CLASS_FACE: n_out.pixel_color = cfg.face_color;
            default:              n_out.pixel_color = cfg.back_color;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_f1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_p1) begin
                r_p1_valid <= i_in_valid;
            end
            if (en_p2) begin
                r_p2_valid <= r_p1_valid;
            end
            if (en_f1) begin
                r_f1_valid <= c_valid[QB];
            end
            if (en_out) begin
                r_out_valid <= r_f1_valid;
            end
        end
    end

    // payload, loaded whenever its stage moves
    always_ff @(posedge i_clk) begin
        if (en_p1) begin
            r_p1_side <= n_p1_side;
            r_p1_m    <= n_p1_m;
        end
        if (en_p2) begin
            r_p2_side  <= r_p1_side;
            r_p2_lane0 <= n_p2_lane0;
            r_p2_lane1 <= n_p2_lane1;
        end
        if (en_f1) begin
            r_f1_side  <= c_side[QB];
            r_f1_ins   <= ins0;
            r_f1_xa    <= n_f1_xa;
            r_f1_zero  <= (ins0 == '0);
            r_f1_steep <= n_f1_steep;
        end
        if (en_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/cbps_checker.sv -----
// ----------------------------------------------------------------------------
// cbps_checker
// port-level checks of the pixel shader, bound to the top level
// ----------------------------------------------------------------------------
`include "capsule_button_pixel_shader_macros.svh"

module cbps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cbps_pkg::t_pix_out o_out_data
);

    // a held result keeps its payload
    `CBPS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "result changed while stalled")

    // input backs up only behind a full pipe and a refused result
    `CBPS_ASSERT_SAME(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled with room downstream")

    // nothing drains while the result stays refused
    `CBPS_ASSERT_NEXT(a_in_stall_keep, o_in_stall, o_in_stall || !i_out_stall, "input freed with output still stalled")

    // class is background, outline or face
    `CBPS_ASSERT_SAME(a_class_code, o_out_valid, $onehot0(o_out_data.pixel_class), "unused class code")

endmodule

bind capsule_button_pixel_shader cbps_checker u_cbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- dv/capsule_button_pixel_shader_tb.sv -----
// ----------------------------------------------------------------------------
// capsule_button_pixel_shader_tb
// self-checking bench: pixel requests go in over a valid/stall channel; each
// result is compared against a typed probe class or an in-bench capsule shader
// that tracks the bus-written registers; directed probes first, then random images
// ----------------------------------------------------------------------------
module capsule_button_pixel_shader_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbps_pkg::*;

    // unused mode code, draws like solid fill
    localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

    localparam int RESET_CYCLES   = 6;
    localparam int PIPE_DEPTH     = ROOT_BITS + 4;
    localparam int END_WAIT       = 2 * PIPE_DEPTH;
    localparam int LONG_HOLD      = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_PHASES     = 12;
    localparam int PHASE_PIXELS   = 65;
    localparam int NUM_PROBES     = 25;

    // one queued request; typed rows carry their class read straight off the spec
    typedef struct {
        t_pix_in    px;
        bit         typed;
        t_pix_class cls;
    } t_pixel_req;

    typedef struct packed {
        logic [MODE_BITS-1:0]         mode;
        logic [COORD_WIDTH_BITS-1:0]  x;
        logic [COORD_HEIGHT_BITS-1:0] y;
        logic                         typed;
        t_pix_class                   cls;
    } t_probe;

    // directed probes on the reset image: 64 x 32, radius 16
    // top row inset is 16, next row 10, rows 15 and 16 touch the sides
    localparam t_probe PROBES [NUM_PROBES] = '{
        // filled capsule
        '{MODE_FILLED,   12'd0,    10'd0,    1'b1, CLASS_BACK},
        '{MODE_FILLED,   12'd15,   10'd0,    1'b1, CLASS_BACK},
        '{MODE_FILLED,   12'd16,   10'd0,    1'b1, CLASS_FACE},
        '{MODE_FILLED,   12'd48,   10'd0,    1'b1, CLASS_BACK},
        '{MODE_FILLED,   12'd0,    10'd15,   1'b1, CLASS_FACE},
        '{MODE_FILLED,   12'd63,   10'd16,   1'b1, CLASS_FACE},
        '{MODE_FILLED,   12'd64,   10'd8,    1'b1, CLASS_BACK},
        '{MODE_FILLED,   12'd4093, 10'd1021, 1'b1, CLASS_BACK},
        '{MODE_FILLED,   12'd10,   10'd4,    1'b0, CLASS_BACK},
        // outlined capsule: edge rows, zero-inset rows, ordinary rows
        '{MODE_OUTLINED, 12'd9,    10'd0,    1'b1, CLASS_BACK},
        '{MODE_OUTLINED, 12'd10,   10'd0,    1'b1, CLASS_EDGE},
        '{MODE_OUTLINED, 12'd54,   10'd0,    1'b1, CLASS_EDGE},
        '{MODE_OUTLINED, 12'd55,   10'd0,    1'b1, CLASS_BACK},
        '{MODE_OUTLINED, 12'd0,    10'd15,   1'b1, CLASS_EDGE},
        '{MODE_OUTLINED, 12'd63,   10'd16,   1'b1, CLASS_EDGE},
        '{MODE_OUTLINED, 12'd30,   10'd15,   1'b1, CLASS_FACE},
        '{MODE_OUTLINED, 12'd10,   10'd1,    1'b0, CLASS_BACK},
        '{MODE_OUTLINED, 12'd6,    10'd3,    1'b0, CLASS_BACK},
        '{MODE_OUTLINED, 12'd5,    10'd31,   1'b0, CLASS_BACK},
        '{MODE_OUTLINED, 12'd0,    10'd8,    1'b0, CLASS_BACK},
        // solid fill
        '{MODE_SOLID,    12'd0,    10'd0,    1'b1, CLASS_FACE},
        '{MODE_SOLID,    12'd63,   10'd31,   1'b1, CLASS_FACE},
        '{MODE_SOLID,    12'd0,    10'd32,   1'b1, CLASS_BACK},
        // spare mode code
        '{MODE_SPARE,    12'd0,    10'd0,    1'b1, CLASS_FACE},
        '{MODE_SPARE,    12'd64,   10'd0,    1'b1, CLASS_BACK}
    };

    // every block input known from time zero
    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_BITS-1:0] paddr       = '0;
    logic [DATA_BITS-1:0] pwdata      = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_pix_in              i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_pix_out             o_out_data;

    // shadow copy of the registers, tracked on every bus write
    logic [COORD_WIDTH_BITS-1:0]  cfg_width  = WIDTH_RESET;
    logic [COORD_HEIGHT_BITS-1:0] cfg_height = HEIGHT_RESET;
    logic [MODE_BITS-1:0]         cfg_mode   = MODE_RESET;
    logic [COLOR_BITS-1:0]        cfg_back   = BACK_RESET;
    logic [COLOR_BITS-1:0]        cfg_edge   = EDGE_RESET;
    logic [COLOR_BITS-1:0]        cfg_face   = FACE_RESET;

    t_pixel_req pixel_queue[$];      // requests waiting for the sender
    t_pix_out   expected_pixels[$];  // shaded pixels owed by the block
    t_pixel_req in_flight_req;

    int  errors          = 0;
    int  requests_queued = 0;
    int  requests_sent   = 0;
    int  results_checked = 0;
    int  hold_requests   = 0;
    int  holds_done      = 0;
    int  send_gap        = 0;
    int  stall_left      = 0;
    int  hold_left       = 0;
    int  quiet_cycles    = 0;
    bit  idle_on         = 1'b1;

    capsule_button_pixel_shader u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // capsule shader
    // ------------------------------------------------------------------------

    function automatic longint floor_sqrt(input longint n);
        longint q;
        q = 0;
        for (int b = 15; b >= 0; b--) begin
            if ((q + (longint'(1) << b)) * (q + (longint'(1) << b)) <= n)
                q += longint'(1) << b;
        end
        return q;
    endfunction

    // inset of mirrored row m: radius minus the rounded half chord,
    // with exact halves rounding the chord down
    function automatic longint capsule_inset(input longint r, input longint m);
        longint d, n, q;
        d = r - m;
        n = r * r - d * d;
        q = floor_sqrt(n);
        return r - (q + ((n > q * q + q) ? 1 : 0));
    endfunction

    function automatic logic [COLOR_BITS-1:0] color_of(input t_pix_class cls);
        case (cls)
            CLASS_BACK: return cfg_back;
            CLASS_EDGE: return cfg_edge;
            default:    return cfg_face;
        endcase
    endfunction

    function automatic t_pix_out shade_pixel(input t_pix_in px);
        longint     w, h, x, y, r, last, m, xi, a, xa;
        t_pix_class cls;
        t_pix_out   res;
        w   = {cfg_width[COORD_WIDTH_BITS-1:1], 1'b0};
        h   = {cfg_height[COORD_HEIGHT_BITS-1:1], 1'b0};
        x   = px.pixel_x;
        y   = px.pixel_y;
        cls = CLASS_BACK;
        if (x < w && y < h) begin
            if (cfg_mode >= MODE_SOLID) begin
                // solid fill and the spare code
                cls = CLASS_FACE;
            end else begin
                r    = h / 2;
                last = h - 1;
                m    = (y >= r) ? last - y : y;
                xi   = capsule_inset(r, m);
                if (cfg_mode == MODE_FILLED) begin
                    cls = (x < xi || x >= w - xi) ? CLASS_BACK : CLASS_FACE;
                end else begin
                    // slope to the next row in, flat on the middle row
                    a  = (m + 1 < r) ? xi - capsule_inset(r, m + 1) : 0;
                    xa = xi - a;
                    if (y == 0 || y == last) begin
                        cls = (x < xa || x > w - xa) ? CLASS_BACK : CLASS_EDGE;
                    end else if (xi == 0) begin
                        cls = (x == 0 || x == w - 1) ? CLASS_EDGE : CLASS_FACE;
                    end else if (a == 0 || xa == 0 || xa == 1) begin
                        // flat or steep row: single outline pixel per side
                        if (x == xi || x == w - xi)
                            cls = CLASS_EDGE;
                        else if (x < xi || x > w - xi)
                            cls = CLASS_BACK;
                        else
                            cls = CLASS_FACE;
                    end else begin
                        // outline run spans the slope
                        if (x < xa || x > w - xa)
                            cls = CLASS_BACK;
                        else if (x >= xi && x <= w - xi)
                            cls = CLASS_FACE;
                        else
                            cls = CLASS_EDGE;
                    end
                end
            end
        end
        res.pixel_class = cls;
        res.pixel_color = color_of(cls);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // pixels cluster on the curved ends, a few land anywhere in the field range
    function automatic t_pix_in random_pixel();
        int      w, h, r, x, y;
        t_pix_in px;
        w = {cfg_width[COORD_WIDTH_BITS-1:1], 1'b0};
        h = {cfg_height[COORD_HEIGHT_BITS-1:1], 1'b0};
        r = h / 2;
        case ($urandom_range(0, 9))
            0:       x = $urandom_range(0, (1 << COORD_WIDTH_BITS) - 1);
            1, 2, 3: x = $urandom_range(0, w + 1);
            4, 5, 6: x = $urandom_range(0, r + 2);
            default: x = w - int'($urandom_range(0, r + 2));
        endcase
        if (x < 0)
            x = 0;
        if ($urandom_range(0, 9) == 0)
            y = $urandom_range(0, (1 << COORD_HEIGHT_BITS) - 1);
        else
            y = $urandom_range(0, h + 1);
        px.pixel_x = x[COORD_WIDTH_BITS-1:0];
        px.pixel_y = y[COORD_HEIGHT_BITS-1:0];
        return px;
    endfunction

    // bus write: setup cycle, access cycle, shadow updated at the write edge
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_BITS-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width  = value[COORD_WIDTH_BITS-1:0];
            REG_HEIGHT: cfg_height = value[COORD_HEIGHT_BITS-1:0];
            REG_MODE:   cfg_mode   = value[MODE_BITS-1:0];
            REG_BACK:   cfg_back   = value[COLOR_BITS-1:0];
            REG_EDGE:   cfg_edge   = value[COLOR_BITS-1:0];
            REG_FACE:   cfg_face   = value[COLOR_BITS-1:0];
            default:    ;
        endcase
    endtask

    // every queued request yields one result, idle once all are checked
    task automatic wait_idle();
        while (results_checked != requests_queued)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // request sender
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : sender
        t_pix_out want;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            // a request offered last cycle went in at this edge
            if (i_in_valid) begin
                if (in_flight_req.typed) begin
                    want.pixel_class = in_flight_req.cls;
                    want.pixel_color = color_of(in_flight_req.cls);
                end else begin
                    want = shade_pixel(in_flight_req.px);
                end
                expected_pixels.insert(expected_pixels.size(), want);
                requests_sent++;
            end
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                in_flight_req = pixel_queue.pop_front();
                i_in_data  <= in_flight_req.px;
                i_in_valid <= 1'b1;
                // gap after this request, valid never looks at stall
                if (idle_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 4);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result receiver: short stall bursts, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_left == 0 && holds_done < hold_requests) begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                // start a random stall burst, this cycle included
                stall_left = $urandom_range(0, 3);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_pix_out want;
        t_pix_out got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_data;
            if (expected_pixels.size() == 0) begin
                $error("result with no request pending: color %06h class %0d",
                       got.pixel_color, got.pixel_class);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                if (got.pixel_color !== want.pixel_color) begin
                    $error("pixel_color mismatch: expected %06h, actual %06h",
                           want.pixel_color, got.pixel_color);
                    errors++;
                end
                if (got.pixel_class !== want.pixel_class) begin
                    $error("pixel_class mismatch: expected %0d, actual %0d",
                           want.pixel_class, got.pixel_class);
                    errors++;
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with work pending and no handshake on either side
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (pixel_queue.size() == 0 && !i_in_valid && expected_pixels.size() == 0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results owed",
                         quiet_cycles, expected_pixels.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        t_pixel_req           req;
        logic [DATA_BITS-1:0] wv, hv, mv;

        // synchronous reset, held low from time zero
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed probes on the reset image, mode switched between groups
        foreach (PROBES[i]) begin
            if (PROBES[i].mode != cfg_mode) begin
                wait_idle();
                write_reg(REG_MODE, DATA_BITS'(PROBES[i].mode));
            end
            req.px.pixel_x = PROBES[i].x;
            req.px.pixel_y = PROBES[i].y;
            req.typed      = PROBES[i].typed;
            req.cls        = PROBES[i].cls;
            pixel_queue.insert(pixel_queue.size(), req);
            requests_queued++;
        end
        wait_idle();

        // random phases, each on its own image setting
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                // largest image, all-ones writes, upper bus bits set too
                0: begin
                    wv = '1;
                    hv = '1;
                    mv = 32'hFFFF_FFFC | DATA_BITS'(MODE_OUTLINED);
                end
                // zero width and zero height: all background
                1: begin
                    wv = 0;
                    hv = 32;
                    mv = DATA_BITS'(MODE_FILLED);
                end
                2: begin
                    wv = 64;
                    hv = 0;
                    mv = DATA_BITS'(MODE_SOLID);
                end
                // smallest capsules, odd sizes rounded down
                3: begin
                    wv = 3;
                    hv = 2;
                    mv = DATA_BITS'(MODE_OUTLINED);
                end
                4: begin
                    wv = 5;
                    hv = 5;
                    mv = DATA_BITS'(MODE_OUTLINED);
                end
                5: begin
                    wv = $urandom_range(0, 300);
                    hv = $urandom_range(0, 120);
                    mv = DATA_BITS'(MODE_SPARE);
                end
                default: begin
                    wv = $urandom_range(0, 300);
                    hv = $urandom_range(0, 120);
                    mv = $urandom_range(0, 3);
                end
            endcase
            write_reg(REG_WIDTH, wv);
            write_reg(REG_HEIGHT, hv);
            write_reg(REG_MODE, mv);
            // color extremes on the first phase, random words after
            write_reg(REG_BACK, (p == 0) ? '0 : $urandom());
            write_reg(REG_EDGE, (p == 0) ? '1 : $urandom());
            write_reg(REG_FACE, (p == 0) ? '0 : $urandom());

            // no idling at all in the closing phases
            idle_on = (p < NUM_PHASES - 2);
            // long output hold-off while the sender keeps offering
            if (p == 3 || p == 8)
                hold_requests++;

            for (int i = 0; i < PHASE_PIXELS; i++) begin
                req.px    = random_pixel();
                req.typed = 1'b0;
                req.cls   = CLASS_BACK;
                pixel_queue.insert(pixel_queue.size(), req);
                requests_queued++;
            end
            wait_idle();
        end

        // let any stray result show up before closing
        repeat (END_WAIT) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            $error("%0d results never arrived", expected_pixels.size());
            errors++;
        end

        $display("run covered %0d pixel requests, %0d results checked", requests_sent,
                 results_checked);
        $display("over %0d image settings in all draw modes, %0d long output hold-offs",
                 NUM_PHASES + 1, holds_done);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cbps_pkg.sv
rtl/cbps_root_cell.sv
rtl/cbps_cfg_regs.sv
rtl/capsule_button_pixel_shader.sv
rtl/cbps_checker.sv
dv/capsule_button_pixel_shader_tb.sv
